// ===== rtl/core/trial_division_prime_test_macros.svh =====
// Assertion macros used by the prime test module.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRDIV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRDIV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/trdiv_pkg.sv =====
package trdiv_pkg;

    // Default width of the tested value.
    localparam int VALUE_WIDTH_DEF = 32;

    // The first divisor tried, and the smallest prime.
    localparam int FIRST_DIVISOR = 2;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== rtl/core/trial_division_prime_test.sv =====
// Trial-division prime tester.
// The input channel (i_valid, o_stall) takes one signed word, i_candidate.
// The output channel (o_valid, i_stall) returns one word per input word:
// o_number_out echoes the candidate and o_is_prime flags a prime.
// A word is moved at a rising edge where valid is high and stall is low.
// Values below two (negative, zero, one) are decided at once, without a trial:
// the word passes through S_DONE to the output register and the block returns to idle.
// Otherwise divisors 2, 3, 4, ... are tried while the divisor does not
// exceed the quotient of the value by it. Each trial is a start strobe, one
// pass of the shared restoring divider over all VALUE_WIDTH dividend bits
// and a decision. A prime takes floor(sqrt(value)) trials, any other value
// its smallest factor less one.
// o_stall is high from acceptance until the result is loaded into the
// output register; one item is in work at a time.
// A result waiting under i_stall is held; a new word may still be taken,
// and its result waits until the output register is free.
// Synchronous active-low reset empties the block and drops o_valid.
`include "trial_division_prime_test_macros.svh"

module trial_division_prime_test #(
    parameter int VALUE_WIDTH = trdiv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_candidate,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_number_out,
    output logic                          o_is_prime
);

    localparam int DIV_WIDTH = VALUE_WIDTH / 2 + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [VALUE_WIDTH-1:0]  r_value, n_value;
    logic [DIV_WIDTH-1:0]    r_div, n_div;
    logic                    r_prime, n_prime;
    logic                    r_start, n_start;
    logic                    r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0]  r_out_num, n_out_num;
    logic                    r_out_prime, n_out_prime;

    logic [VALUE_WIDTH-1:0]  w_quo;
    logic [DIV_WIDTH-1:0]    w_rem;
    trdiv_pkg::t_div_status  w_div_status;
    logic [VALUE_WIDTH-1:0]  w_cand;

    // Shared divider: one quotient and remainder per trial divisor.
    trdiv_divider #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DIV_WIDTH)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_dividend  (r_value),
        .i_divisor   (r_div),
        .o_quotient  (w_quo),
        .o_remainder (w_rem),
        .o_status    (w_div_status)
    );

    assign w_cand = $unsigned(i_candidate);

    // Sequencer: accept, iterate over divisors, then hand the result over.
    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_div       = r_div;
        n_prime     = r_prime;
        n_start     = 1'b0;
        n_out_valid = r_out_valid & i_stall;
        n_out_num   = r_out_num;
        n_out_prime = r_out_prime;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_value = w_cand;
                    if (w_cand[VALUE_WIDTH-1] ||
                        (w_cand < VALUE_WIDTH'(trdiv_pkg::FIRST_DIVISOR))) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_div   = DIV_WIDTH'(trdiv_pkg::FIRST_DIVISOR);
                        n_start = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_status.done) begin
                    if (VALUE_WIDTH'(r_div) > w_quo) begin
                        // No divisor up to the square root divides the value.
                        n_prime = 1'b1;
                        n_div   = DIV_WIDTH'(trdiv_pkg::FIRST_DIVISOR);
                        n_state = S_DONE;
                    end else if (w_rem == '0) begin
                        n_prime = 1'b0;
                        n_div   = DIV_WIDTH'(trdiv_pkg::FIRST_DIVISOR);
                        n_state = S_DONE;
                    end else begin
                        n_div   = r_div + 1'b1;
                        n_start = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_num   = r_value;
                    n_out_prime = r_prime;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_value     <= '0;
            r_div       <= DIV_WIDTH'(trdiv_pkg::FIRST_DIVISOR);
            r_prime     <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_value     <= n_value;
            r_div       <= n_div;
            r_prime     <= n_prime;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
        r_out_num   <= n_out_num;
        r_out_prime <= n_out_prime;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_number_out = $signed(r_out_num);
    assign o_is_prime   = r_out_prime;

    // Checks on the sequencer and the divider hand-off.
    `TRDIV_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_valid && !o_stall,
        r_state == S_DIV || r_state == S_DONE, "accepted word did not start a test")
    `TRDIV_ASSERT_SAME(a_start_in_div, i_clk, i_rst_n, r_start,
        r_state == S_DIV && !w_div_status.busy, "divider started outside a test")
    `TRDIV_ASSERT_SAME(a_divisor_floor, i_clk, i_rst_n, r_state == S_DIV,
        r_div >= DIV_WIDTH'(trdiv_pkg::FIRST_DIVISOR), "trial divisor below two")
    `TRDIV_ASSERT_SAME(a_prime_positive, i_clk, i_rst_n, o_valid && o_is_prime,
        !r_out_num[VALUE_WIDTH-1] && (r_out_num >= VALUE_WIDTH'(trdiv_pkg::FIRST_DIVISOR)),
        "value below two flagged prime")

endmodule

// ===== rtl/core/trdiv_divider.sv =====
module trdiv_divider #(
    parameter int VALUE_WIDTH = trdiv_pkg::VALUE_WIDTH_DEF,
    parameter int DIV_WIDTH   = VALUE_WIDTH / 2 + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [VALUE_WIDTH-1:0]   i_dividend,
    input  logic [DIV_WIDTH-1:0]     i_divisor,
    output logic [VALUE_WIDTH-1:0]   o_quotient,
    output logic [DIV_WIDTH-1:0]     o_remainder,
    output trdiv_pkg::t_div_status   o_status
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [DIV_WIDTH-1:0]   r_rem;
    logic [DIV_WIDTH-1:0]   r_dvs;

    logic [DIV_WIDTH:0]     w_trial;
    logic [DIV_WIDTH:0]     w_diff;
    logic                   n_bit;
    logic [DIV_WIDTH-1:0]   n_rem;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        w_trial = {r_rem, r_quo[VALUE_WIDTH-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        n_bit   = ~w_diff[DIV_WIDTH];
        n_rem   = n_bit ? w_diff[DIV_WIDTH-1:0] : w_trial[DIV_WIDTH-1:0];
    end

    // Step counter and datapath, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= CW'(VALUE_WIDTH);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[VALUE_WIDTH-2:0], n_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient    = r_quo;
    assign o_remainder   = r_rem;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = trdiv_pkg::VALUE_WIDTH_DEF;
    localparam int HOLD_CYCLES = 20000;

    typedef logic signed [WIDTH-1:0] t_number;

    // One expected result word: the echoed number and its prime flag.
    typedef struct {
        t_number number;
        logic    prime;
    } t_verdict;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    i_stall = 1'b0;
    t_number i_candidate = '0;
    logic    o_stall;
    logic    o_valid;
    t_number o_number_out;
    logic    o_is_prime;

    t_number  untested_q[$];
    t_verdict verdict_q[$];
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       hold_left = 0;
    logic     hold_start = 1'b0;
    int       fail_count = 0;

    trial_division_prime_test #(
        .VALUE_WIDTH(WIDTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_candidate  (i_candidate),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_number_out (o_number_out),
        .o_is_prime   (o_is_prime)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Trial division over a 64-bit square, so the top of the range is exact.
    function automatic logic prime_by_trial(t_number value);
        longint unsigned n;
        longint unsigned divisor;
        if (value < 2) return 1'b0;
        n = {32'd0, value};
        for (divisor = trdiv_pkg::FIRST_DIVISOR; divisor * divisor <= n; divisor++) begin
            if (n % divisor == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Random candidates stay cheap: positive full-width words are made even,
    // so a prime that needs tens of thousands of trials never comes up.
    function automatic t_number random_candidate();
        int      kind;
        int      p;
        t_number word;
        kind = $urandom_range(99);
        if (kind < 45) begin
            word = $urandom_range(4095);
        end else if (kind < 60) begin
            word = $urandom_range(65535);
        end else if (kind < 75) begin
            word = $urandom;
            word[0] = 1'b0;
        end else if (kind < 85) begin
            word = $urandom;
            word[WIDTH-1] = 1'b1;
        end else begin
            // Squares and near squares of p put the deciding divisor at the bound when p is prime.
            p = $urandom_range(250, 2);
            word = $urandom_range(1) ? p * p : p * (p + 2);
        end
        return word;
    endfunction

    // Driver: offers the next pending word and records its verdict on acceptance.
    always @(posedge i_clk) begin : drive_words
        t_verdict want;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                want.number = i_candidate;
                want.prime = prime_by_trial(i_candidate);
                verdict_q.insert(verdict_q.size(), want);
            end
            if (!i_valid || !o_stall) begin
                if (untested_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_candidate <= untested_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compares every accepted result word with the oldest verdict.
    always @(posedge i_clk) begin : check_words
        t_verdict want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result word: number_out %0d", o_number_out);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_number_out !== want.number) begin
                        $error("number_out: expected %0d, actual %0d",
                               want.number, o_number_out);
                        fail_count++;
                    end
                    if (o_is_prime !== want.prime) begin
                        $error("is_prime: expected %0b, actual %0b (number %0d)",
                               want.prime, o_is_prime, want.number);
                        fail_count++;
                    end
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // Waits until every word has been taken and every result has come back.
    task automatic wait_drained();
        while (untested_q.size() != 0 || i_valid || verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int tx_idle, int rx_stall, bit squeeze);
        send_idle_pct <= tx_idle;
        stall_pct <= rx_stall;
        repeat (count) untested_q.insert(untested_q.size(), random_candidate());
        if (squeeze) begin
            hold_start <= 1'b1;
            @(posedge i_clk);
            hold_start <= 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: range ends, small primes, squares of primes, bit patterns.
        untested_q = '{
            32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd4,
            32'sd5, 32'sd9, 32'sd25, 32'sd49, 32'sd121, 32'sd7919, 32'sd65537,
            32'sh4000_0000, 32'sh5555_5555, 32'sh2AAA_AAAA, 32'sh7FFF_FFFE,
            32'sh7FFF_FFFD, 32'sh7FFF_FFFF
        };
        wait_drained();

        // Random words under each idling pattern; the first also fills the block.
        run_phase(25, 0, 0, 1'b1);
        run_phase(25, 87, 0, 1'b0);
        run_phase(25, 0, 87, 1'b0);
        run_phase(25, 20, 20, 1'b0);

        stall_pct <= 0;
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/trdiv_pkg.sv
rtl/core/trdiv_divider.sv
rtl/core/trial_division_prime_test.sv
dv/testbench.sv
